// ===== hdl/audio_peak_level_meter_defines.svh =====
// Assertion macros for the peak level meter checker.
// Expects clk and rst_n in the scope of each use.
`ifndef AUDIO_PEAK_LEVEL_METER_DEFINES_SVH
`define AUDIO_PEAK_LEVEL_METER_DEFINES_SVH

// Checked only outside reset.
`define APLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define APLM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/aplm_pkg.sv =====
// Shared types and constants for the audio peak level meter.
// No dependencies; every other file of the block but the assertion macro header uses it.
package aplm_pkg;

  localparam int LVL_W      = 16;
  localparam int FACTOR_W   = 16;
  localparam int FMT_W      = 3;
  localparam int OP_W       = 3;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 4;
  localparam int QA_W       = $clog2(QDEPTH);

  localparam logic [LVL_W-1:0] FULL_SCALE = 16'd32768;

  // Opcodes of an input word
  localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_LAST   = 3'd1;
  localparam logic [OP_W-1:0] OP_END    = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Sample formats
  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_F32 = 3'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd3;

  localparam logic [FMT_W-1:0]    RST_FORMAT = FMT_S16;
  localparam logic [FACTOR_W-1:0] RST_ATTACK = 16'd29491;
  localparam logic [FACTOR_W-1:0] RST_DECAY  = 16'd53740;
  localparam logic [LVL_W-1:0]    RST_FLOOR  = 16'd328;

  typedef enum logic [2:0] {
    K_SAMPLE = 3'd0,
    K_LAST   = 3'd1,
    K_END    = 3'd2,
    K_TICK   = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [LVL_W-1:0] mag;
  } q_entry_t;

  typedef struct packed {
    logic [FMT_W-1:0]    fmt;
    logic [FACTOR_W-1:0] attack;
    logic [FACTOR_W-1:0] decay;
    logic [LVL_W-1:0]    floor_lvl;
  } cfg_t;

endpackage

// ===== hdl/aplm_in_if.sv =====
// Input channel of the peak level meter: opcode and raw sample word.
// Depends on aplm_pkg for widths.
interface aplm_in_if;
  logic                          valid;
  logic                          ready;
  logic [aplm_pkg::OP_W-1:0]     opcode;
  logic [aplm_pkg::SAMPLE_W-1:0] sample_bits;

  modport source (output valid, output opcode, output sample_bits, input ready);
  modport sink   (input valid, input opcode, input sample_bits, output ready);
endinterface

// ===== hdl/aplm_out_if.sv =====
// Result channel of the peak level meter: one level word per result.
// Depends on aplm_pkg for widths.
interface aplm_out_if;
  logic                       valid;
  logic                       ready;
  logic [aplm_pkg::LVL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ===== hdl/aplm_front.sv =====
// Front end: accepts input words, converts samples to Q1.15 magnitude,
// drops unknown opcodes and pushes the rest to the queue. Uses aplm_pkg.
module aplm_front (
  input  logic [aplm_pkg::FMT_W-1:0]    fmt,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aplm_pkg::OP_W-1:0]     in_opcode,
  input  logic [aplm_pkg::SAMPLE_W-1:0] in_sample_bits,
  input  logic                          q_full,
  output logic                          q_push,
  output aplm_pkg::q_entry_t            q_wdata
);

  function automatic logic [aplm_pkg::LVL_W-1:0] mag_of(
    input logic [aplm_pkg::FMT_W-1:0]    f,
    input logic [aplm_pkg::SAMPLE_W-1:0] b
  );
    logic [16:0] m;
    logic [7:0]  u;
    logic [15:0] s16;
    logic [31:0] a32;
    logic [7:0]  ex;
    logic [23:0] man;
    logic [4:0]  sh;
    u   = b[7:0];
    s16 = b[15] ? (16'd0 - b[15:0]) : b[15:0];
    a32 = b[31] ? (32'd0 - b) : b;
    ex  = b[30:23];
    man = {1'b1, b[22:0]};
    sh  = 5'(8'd135 - ex);
    case (f)
      aplm_pkg::FMT_U8:  m = {1'b0, (u[7] ? (u - 8'd128) : (8'd128 - u)), 8'd0};
      aplm_pkg::FMT_S16: m = {1'b0, s16};
      aplm_pkg::FMT_S32: m = {1'b0, a32[31:16]};
      aplm_pkg::FMT_F32: begin
        if (ex == 8'hFF) begin
          // NaN never raises the peak, infinity is full scale
          m = (b[22:0] != 23'd0) ? 17'd0 : {1'b0, aplm_pkg::FULL_SCALE};
        end else if (ex >= 8'd127) begin
          m = {1'b0, aplm_pkg::FULL_SCALE};
        end else if (ex < 8'd112) begin
          m = 17'd0;
        end else begin
          m = {1'b0, 16'(man >> sh)};
        end
      end
      default: m = 17'd0;
    endcase
    return (m > {1'b0, aplm_pkg::FULL_SCALE}) ? aplm_pkg::FULL_SCALE : m[15:0];
  endfunction

  logic known_op;

  assign known_op = (in_opcode == aplm_pkg::OP_SAMPLE) || (in_opcode == aplm_pkg::OP_LAST) ||
                    (in_opcode == aplm_pkg::OP_END)    || (in_opcode == aplm_pkg::OP_TICK) ||
                    (in_opcode == aplm_pkg::OP_CLEAR);

  assign in_ready = !q_full;
  // Unknown opcodes are taken and dropped here
  assign q_push   = in_valid && in_ready && known_op;

  always_comb begin
    q_wdata.mag = mag_of(fmt, in_sample_bits);
    unique case (in_opcode)
      aplm_pkg::OP_SAMPLE: q_wdata.kind = aplm_pkg::K_SAMPLE;
      aplm_pkg::OP_LAST:   q_wdata.kind = aplm_pkg::K_LAST;
      aplm_pkg::OP_END:    q_wdata.kind = aplm_pkg::K_END;
      aplm_pkg::OP_TICK:   q_wdata.kind = aplm_pkg::K_TICK;
      default:             q_wdata.kind = aplm_pkg::K_CLEAR;
    endcase
  end

endmodule

// ===== hdl/aplm_queue.sv =====
// Short FIFO between the front end and the back end.
// Uses aplm_pkg for depth and entry type.
module aplm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  aplm_pkg::q_entry_t wdata,
  input  logic               pop,
  output aplm_pkg::q_entry_t rdata,
  output logic               full,
  output logic               empty
);

  aplm_pkg::q_entry_t              mem_r [aplm_pkg::QDEPTH];
  logic [aplm_pkg::QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [aplm_pkg::QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [aplm_pkg::QA_W:0]   count_r, count_nxt;

  assign full  = (count_r == (aplm_pkg::QA_W+1)'(aplm_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hdl/aplm_back.sv =====
// Back end: holds buffer peak and meter level, applies attack, decay and
// clear, and drives the result output register. Uses aplm_pkg.
module aplm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  aplm_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  input  aplm_pkg::q_entry_t         q_rdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [aplm_pkg::LVL_W-1:0] out_level
);

  logic [aplm_pkg::LVL_W-1:0] peak_r, peak_nxt;
  logic [aplm_pkg::LVL_W-1:0] level_r, level_nxt;
  logic                       ovalid_r, ovalid_nxt;
  logic [aplm_pkg::LVL_W-1:0] olevel_r, olevel_nxt;
  logic [31:0]                prod_att, prod_dec;
  logic [aplm_pkg::LVL_W-1:0] held, decayed, pk;
  logic                       emit;

  // Advance whenever the output slot is free or being emptied
  assign q_pop = !q_empty && (!ovalid_r || out_ready);

  assign prod_att = {16'd0, level_r} * {16'd0, cfg.attack};
  assign prod_dec = {16'd0, level_r} * {16'd0, cfg.decay};
  assign held     = prod_att[31:16];
  assign decayed  = prod_dec[31:16];
  assign pk       = (q_rdata.mag > peak_r) ? q_rdata.mag : peak_r;

  always_comb begin
    peak_nxt  = peak_r;
    level_nxt = level_r;
    emit      = 1'b0;
    if (q_pop) begin
      case (q_rdata.kind)
        aplm_pkg::K_SAMPLE: peak_nxt = pk;
        aplm_pkg::K_LAST: begin
          level_nxt = (held > pk) ? held : pk;
          peak_nxt  = '0;
          emit      = 1'b1;
        end
        aplm_pkg::K_END: begin
          level_nxt = (held > peak_r) ? held : peak_r;
          peak_nxt  = '0;
          emit      = 1'b1;
        end
        aplm_pkg::K_TICK: begin
          level_nxt = (decayed < cfg.floor_lvl) ? '0 : decayed;
          emit      = 1'b1;
        end
        default: begin
          level_nxt = '0;
          peak_nxt  = '0;
          emit      = (level_r != '0);
        end
      endcase
    end
    ovalid_nxt = ovalid_r && !out_ready;
    olevel_nxt = olevel_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      olevel_nxt = level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r   <= '0;
      level_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      peak_r   <= peak_nxt;
      level_r  <= level_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    olevel_r <= olevel_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_level = olevel_r;

endmodule

// ===== hdl/audio_peak_level_meter.sv =====
// Audio peak level meter: top level with configuration registers.
// A result word passes through the queue and then the back end's output register after its input word is accepted.
// Throughput: one input word per cycle while the queue is not full; the four-entry queue absorbs output stalls.
// Rate is set by the combinational level update (an attack or decay multiply and compare) in the back end.
// Reset (rst_n low, synchronous): level, peak, queue and output valid clear;
// registers return to int16 format, attack 29491, decay 53740, floor 328.
module audio_peak_level_meter (
  input  logic                           clk,
  input  logic                           rst_n,
  aplm_in_if.sink                        in_ch,
  aplm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [aplm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aplm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it
  aplm_pkg::cfg_t     cfg_r, cfg_nxt;

  // Queue between the front end and the back end
  logic               q_push, q_pop, q_full, q_empty;
  aplm_pkg::q_entry_t q_wdata, q_rdata;

  // Decode a register write; every index of the port maps to a register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        aplm_pkg::CFG_FORMAT: cfg_nxt.fmt       = cfg_wdata[aplm_pkg::FMT_W-1:0];
        aplm_pkg::CFG_ATTACK: cfg_nxt.attack    = cfg_wdata;
        aplm_pkg::CFG_DECAY:  cfg_nxt.decay     = cfg_wdata;
        default:              cfg_nxt.floor_lvl = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt       <= aplm_pkg::RST_FORMAT;
      cfg_r.attack    <= aplm_pkg::RST_ATTACK;
      cfg_r.decay     <= aplm_pkg::RST_DECAY;
      cfg_r.floor_lvl <= aplm_pkg::RST_FLOOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify words and convert samples to magnitude in the accept cycle
  aplm_front u_front (
    .fmt            (cfg_r.fmt),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_opcode      (in_ch.opcode),
    .in_sample_bits (in_ch.sample_bits),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Hold classified words until the back end can take them
  aplm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Update peak and level, and register the result word
  aplm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_level (out_ch.level)
  );

endmodule

// ===== hdl/aplm_checker.sv =====
// Port-level checker for the audio peak level meter, bound to the top level.
// Depends on aplm_pkg and audio_peak_level_meter_defines.svh.
`include "audio_peak_level_meter_defines.svh"

module aplm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [aplm_pkg::LVL_W-1:0] out_level
);

  // A level never exceeds full scale
  `APLM_ASSERT(a_level_range, out_valid |-> (out_level <= aplm_pkg::FULL_SCALE), "level above full scale")
  // A stalled result word holds
  `APLM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_level)), "stalled word changed")
  // Reset drops any pending result
  `APLM_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")
  // Reset empties the queue, so input is taken right after
  `APLM_ASSERT_RST(a_rst_ready, !rst_n |=> in_ready, "not ready after reset")

endmodule

bind audio_peak_level_meter aplm_checker u_aplm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.level)
);
